### rtl/ttu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ttu_pkg;
	localparam int OUT_FRAC = 30;
	localparam int MW = 33;
	localparam int PW = 66;
	localparam int AW = 67;
	localparam int RW = 36;
	localparam logic [31:0] OUT_LIM = 32'd1 << OUT_FRAC;

	typedef struct packed {
		logic ge;
		logic [RW-1:0] diff;
	} step_res_t;
endpackage
`default_nettype wire

### rtl/triangle_tangent_from_uv.sv
// The first and second vertex of a triangle are taken from idle without a stall.
// The third vertex starts multiply, normalise shifts, square-sum, 32 square-root
// steps and a divide per component; a degenerate triangle goes straight to the result.
// No new vertex is taken until the result is loaded into the output register. One shared
// compare-subtract unit runs both the square root and the divides.
// Reset: arst_n clears the sequencer, vertex count and output valid at once.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_from_uv (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [31:0] tex_u,
	input  wire logic [31:0] tex_v,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      tangent_x,
	output logic [31:0]      tangent_y,
	output logic [31:0]      tangent_z,
	output logic             degenerate
);
	localparam int MW = ttu_pkg::MW;
	localparam int PW = ttu_pkg::PW;
	localparam int AW = ttu_pkg::AW;
	localparam int RW = ttu_pkg::RW;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_CHK, S_NORM, S_SQ, S_SQRT, S_DIVI, S_DIV, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] corner_q;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;
	logic [31:0] v0_q [0:4];
	logic [31:0] v1_q [0:4];
	logic [31:0] v2_q [0:4];
	logic signed [AW-1:0] acc_q [0:3];
	logic [PW-1:0] mag_q [0:2];
	logic [2:0] tneg_q;
	logic dneg_q;
	logic [63:0] sum_q;
	logic [63:0] x_q;
	logic [RW-1:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] num_q;
	logic [31:0] quo_q;
	logic [31:0] res_q [0:2];
	logic degen_q;

	logic signed [MW-1:0] du0, dv0, du1, dv1;
	logic signed [MW-1:0] e0 [0:2];
	logic signed [MW-1:0] e1 [0:2];
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_s1;
	logic [RW-1:0] step_rem, step_sub, sqrt_sh, div_sh;
	ttu_pkg::step_res_t step;
	logic [PW-1:0] mag_c [0:2];
	logic [PW-1:0] mag_or;
	logic [4:0] jw;
	logic [1:0] tgt;
	logic [63:0] numer;
	logic [31:0] qf, qs;

	function automatic logic signed [MW-1:0] sdiff(input logic [31:0] a, input logic [31:0] b);
		sdiff = $signed({a[31], a}) - $signed({b[31], b});
	endfunction

	always_comb begin
		du0 = sdiff(v1_q[3], v0_q[3]);
		dv0 = sdiff(v1_q[4], v0_q[4]);
		du1 = sdiff(v2_q[3], v0_q[3]);
		dv1 = sdiff(v2_q[4], v0_q[4]);
		for (int i = 0; i < 3; i++) begin
			e0[i] = sdiff(v1_q[i], v0_q[i]);
			e1[i] = sdiff(v2_q[i], v0_q[i]);
		end
		if (state_q == S_SQ) begin
			mul_a = $signed({1'b0, mag_q[cnt_q[1:0] == 2'd3 ? 2'd0 : cnt_q[1:0]][31:0]});
			mul_b = mul_a;
		end else begin
			case (cnt_q[2:0])
				3'd0: begin mul_a = du0; mul_b = dv1; end
				3'd1: begin mul_a = du1; mul_b = dv0; end
				3'd2: begin mul_a = dv1; mul_b = e0[0]; end
				3'd3: begin mul_a = dv0; mul_b = e1[0]; end
				3'd4: begin mul_a = dv1; mul_b = e0[1]; end
				3'd5: begin mul_a = dv0; mul_b = e1[1]; end
				3'd6: begin mul_a = dv1; mul_b = e0[2]; end
				default: begin mul_a = dv0; mul_b = e1[2]; end
			endcase
		end
	end

	ttu_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_s1(prod_s1));

	always_comb begin
		sqrt_sh = {rem_q[RW-3:0], x_q[63:62]};
		div_sh = {rem_q[RW-2:0], num_q[31]};
		step_rem = (state_q == S_SQRT) ? sqrt_sh : div_sh;
		step_sub = (state_q == S_SQRT) ? {2'b00, root_q, 2'b01} : {4'b0000, root_q};
	end

	ttu_rstep u_step (.rem(step_rem), .sub(step_sub), .res(step));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = acc_q[i+1][AW-1] ? PW'(-acc_q[i+1]) : PW'(acc_q[i+1]);
		end
		mag_or = mag_q[0] | mag_q[1] | mag_q[2];
		jw = cnt_q - 5'd1;
		tgt = jw[2:1];
		numer = ({32'd0, mag_q[comp_q][31:0]} << ttu_pkg::OUT_FRAC) + {33'd0, root_q[31:1]};
		qf = {quo_q[30:0], step.ge};
		qs = (qf > ttu_pkg::OUT_LIM) ? ttu_pkg::OUT_LIM : qf;
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			corner_q <= 2'd0;
			cnt_q <= 5'd0;
			comp_q <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (corner_q == 2'd0) begin
							v0_q <= '{pos_x, pos_y, pos_z, tex_u, tex_v};
							corner_q <= 2'd1;
						end else if (corner_q == 2'd1) begin
							v1_q <= '{pos_x, pos_y, pos_z, tex_u, tex_v};
							corner_q <= 2'd2;
						end else begin
							v2_q <= '{pos_x, pos_y, pos_z, tex_u, tex_v};
							corner_q <= 2'd0;
							cnt_q <= 5'd0;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (cnt_q != 5'd0) begin
						if (!jw[0]) begin
							acc_q[tgt] <= {prod_s1[PW-1], prod_s1};
						end else begin
							acc_q[tgt] <= acc_q[tgt] - {prod_s1[PW-1], prod_s1};
						end
					end
					if (cnt_q == 5'd8) begin
						state_q <= S_CHK;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				S_CHK: begin
					dneg_q <= acc_q[0][AW-1];
					for (int i = 0; i < 3; i++) begin
						tneg_q[i] <= acc_q[i+1][AW-1];
						mag_q[i] <= mag_c[i];
					end
					if (acc_q[0] == '0 || (mag_c[0] | mag_c[1] | mag_c[2]) == '0) begin
						res_q <= '{32'd0, 32'd0, 32'd0};
						degen_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (|mag_or[PW-1:31]) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (!mag_or[30]) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						cnt_q <= 5'd0;
						sum_q <= 64'd0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q != 5'd0) begin
						sum_q <= sum_q + prod_s1[63:0];
					end
					if (cnt_q == 5'd3) begin
						x_q <= sum_q + prod_s1[63:0];
						rem_q <= '0;
						root_q <= 32'd0;
						cnt_q <= 5'd0;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_SQRT: begin
					x_q <= x_q << 2;
					if (step.ge) begin
						rem_q <= step.diff;
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q <= sqrt_sh;
						root_q <= {root_q[30:0], 1'b0};
					end
					if (cnt_q == 5'd31) begin
						comp_q <= 2'd0;
						state_q <= S_DIVI;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				S_DIVI: begin
					rem_q <= {4'b0000, numer[63:32]};
					num_q <= numer[31:0];
					quo_q <= 32'd0;
					cnt_q <= 5'd0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					num_q <= num_q << 1;
					rem_q <= step.ge ? step.diff : div_sh;
					quo_q <= qf;
					if (cnt_q == 5'd31) begin
						res_q[comp_q] <= (tneg_q[comp_q] ^ dneg_q) ? (32'd0 - qs) : qs;
						degen_q <= 1'b0;
						if (comp_q == 2'd2) begin
							state_q <= S_DONE;
						end else begin
							comp_q <= comp_q + 2'd1;
							state_q <= S_DIVI;
						end
					end
					cnt_q <= cnt_q + 5'd1;
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						tangent_x <= res_q[0];
						tangent_y <= res_q[1];
						tangent_z <= res_q[2];
						degenerate <= degen_q;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/ttu_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module ttu_mul (
	input  wire logic                              clk,
	input  wire logic signed [ttu_pkg::MW-1:0]     a,
	input  wire logic signed [ttu_pkg::MW-1:0]     b,
	output logic signed [ttu_pkg::PW-1:0]          p_s1
);
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end
endmodule
`default_nettype wire

### rtl/ttu_rstep.sv
`timescale 1ns / 1ps
`default_nettype none
module ttu_rstep (
	input  wire logic [ttu_pkg::RW-1:0] rem,
	input  wire logic [ttu_pkg::RW-1:0] sub,
	output ttu_pkg::step_res_t          res
);
	always_comb begin
		res.ge = rem >= sub;
		res.diff = rem - sub;
	end
endmodule
`default_nettype wire

### rtl/ttu_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module ttu_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] tangent_x,
	input wire logic [31:0] tangent_y,
	input wire logic [31:0] tangent_z,
	input wire logic        degenerate
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(tangent_x) && $stable(tangent_y)
			&& $stable(tangent_z) && $stable(degenerate))
		else $error("stalled result changed");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tangent_x == 32'd0 && tangent_y == 32'd0
			&& tangent_z == 32'd0)
		else $error("degenerate result with non-zero tangent");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(tangent_x) <= 32'sd1073741824
			&& $signed(tangent_x) >= -32'sd1073741824
			&& $signed(tangent_y) <= 32'sd1073741824
			&& $signed(tangent_y) >= -32'sd1073741824
			&& $signed(tangent_z) <= 32'sd1073741824
			&& $signed(tangent_z) >= -32'sd1073741824)
		else $error("tangent component out of unit range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request in flight");
endmodule

bind triangle_tangent_from_uv ttu_chk u_ttu_chk (.*);
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	typedef struct {
		logic [31:0] tx;
		logic [31:0] ty;
		logic [31:0] tz;
		logic        degen;
	} tangent_t;

	class tangent_board;
		logic signed [31:0] first_v[5];
		logic signed [31:0] second_v[5];
		int                 corners;
		tangent_t           pending[$];
		int                 errors;

		function new();
			corners = 0;
			errors = 0;
		endfunction

		// full-width signed products: 33-bit edges, 66-bit products, 67-bit diffs
		function void note_vertex(logic signed [31:0] v[5]);
			logic signed [32:0]  d0[5], d1[5];
			logic signed [66:0]  det, t[3];
			logic [66:0]         mag[3];
			logic [63:0]         m[3], s, len, rem, q, lim;
			int                  best, shift, n;
			tangent_t            r;
			if (corners == 0) begin
				first_v = v;
				corners = 1;
				return;
			end
			if (corners == 1) begin
				second_v = v;
				corners = 2;
				return;
			end
			corners = 0;
			for (int i = 0; i < 5; i++) begin
				d0[i] = 33'(second_v[i]) - 33'(first_v[i]);
				d1[i] = 33'(v[i]) - 33'(first_v[i]);
			end
			det = 67'(d0[3]) * 67'(d1[4]) - 67'(d1[3]) * 67'(d0[4]);
			best = 0;
			for (int i = 0; i < 3; i++) begin
				t[i] = 67'(d1[4]) * 67'(d0[i]) - 67'(d0[4]) * 67'(d1[i]);
				mag[i] = t[i] < 0 ? -t[i] : t[i];
				n = 0;
				for (int b = 0; b < 67; b++)
					if (mag[i][b]) n = b + 1;
				if (n > best) best = n;
			end
			r = '{0, 0, 0, 1'b1};
			if (det != 0 && best != 0) begin
				shift = best - 31;
				s = 0;
				for (int i = 0; i < 3; i++) begin
					m[i] = shift > 0 ? 64'(mag[i] >> shift) : 64'(mag[i] << (-shift));
					s += m[i] * m[i];
				end
				len = 0;
				rem = s;
				for (int b = 31; b >= 0; b--)
					if ((len | (64'd1 << b)) * (len | (64'd1 << b)) <= rem)
						len |= 64'd1 << b;
				lim = 64'd1 << ttu_pkg::OUT_FRAC;
				for (int i = 0; i < 3; i++) begin
					q = ((m[i] << ttu_pkg::OUT_FRAC) + (len >> 1)) / len;
					if (q > lim) q = lim;
					if ((t[i] < 0) != (det < 0)) q = -q;
					if (i == 0) r.tx = q[31:0];
					else if (i == 1) r.ty = q[31:0];
					else r.tz = q[31:0];
				end
				r.degen = 1'b0;
			end
			pending.push_back(r);
		endfunction

		function void check_tangent(tangent_t got);
			tangent_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %b", $time,
					got.tx, got.ty, got.tz, got.degen);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.tx !== want.tx) begin
				$display("%0t: tangent_x exp %h got %h", $time, want.tx, got.tx);
				errors++;
			end
			if (got.ty !== want.ty) begin
				$display("%0t: tangent_y exp %h got %h", $time, want.ty, got.ty);
				errors++;
			end
			if (got.tz !== want.tz) begin
				$display("%0t: tangent_z exp %h got %h", $time, want.tz, got.tz);
				errors++;
			end
			if (got.degen !== want.degen) begin
				$display("%0t: degenerate exp %b got %b", $time, want.degen, got.degen);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [31:0] tangent_x, tangent_y, tangent_z;
	logic        degenerate;

	tangent_board board = new();
	int           cycles = 0;
	int           triangles = 0, flat_ones = 0;

	triangle_tangent_from_uv u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && in_valid && !in_stall) begin
			logic signed [31:0] v[5];
			v = '{pos_x, pos_y, pos_z, tex_u, tex_v};
			board.note_vertex(v);
		end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) begin
			board.check_tangent('{tangent_x, tangent_y, tangent_z, degenerate});
			triangles++;
			if (degenerate) flat_ones++;
		end

	// receiver: stall for a random spell, then take one result
	initial begin
		@(posedge arst_n);
		forever begin
			if ($urandom_range(3) == 0)
				out_stall <= 1'b0;
			else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(8)) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_vertex(logic [31:0] x, y, z, u, v);
		if ($urandom_range(3) != 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= x; pos_y <= y; pos_z <= z; tex_u <= u; tex_v <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			2: return 32'h8000_0000 + $urandom_range(3);
			3: return 32'h7fff_fffc + $urandom_range(3);
			default: return 32'($signed($urandom_range(200000)) - 100000);
		endcase
	endfunction

	initial begin
		logic [31:0] a, b;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// ordinary triangle
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(32'h10000, 0, 0, 32'h10000, 0);
		send_vertex(0, 32'h10000, 0, 0, 32'h10000);
		// flipped winding in uv: negative determinant
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(32'h10000, 0, 0, 0, 32'h10000);
		send_vertex(0, 32'h10000, 0, 32'h10000, 0);
		// zero determinant: collinear uv
		send_vertex(1, 2, 3, 5, 5);
		send_vertex(4, 5, 6, 6, 6);
		send_vertex(7, 8, 9, 7, 7);
		// zero tangent length: all positions equal
		send_vertex(9, 9, 9, 0, 0);
		send_vertex(9, 9, 9, 32'h10000, 0);
		send_vertex(9, 9, 9, 0, 32'h10000);
		// field extremes
		send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		send_vertex('1, '1, '1, '1, 0);
		send_vertex(0, 0, 0, 0, '1);
		send_vertex(32'h7fff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		// tiny tangent needing left shift
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(1, 0, 0, 1, 0);
		send_vertex(0, 1, 0, 0, 1);
		for (int i = 0; i < 700; i++) begin
			if (i % 3 == 1 && $urandom_range(9) == 0) begin
				a = $urandom; b = $urandom;
				send_vertex(pick_value(), pick_value(), pick_value(), a, b);
			end else
				send_vertex(pick_value(), pick_value(), pick_value(),
					pick_value(), pick_value());
		end
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d triangles, %0d of them degenerate", triangles, flat_ones);
		if (board.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
`default_nettype wire
